// ===== rtl/tbcs_pkg.sv =====
`default_nettype none
package tbcs_pkg;

	localparam int CW   = 16;          // coordinate width
	localparam int EW   = CW + 1;      // edge component
	localparam int PW   = 2 * EW;      // edge product
	localparam int NW   = PW + 1;      // normal component
	localparam int BBW  = 2 * CW;      // vertex component squared
	localparam int B2W  = BBW + 2;     // |b|^2
	localparam int NBW  = NW + CW;     // normal times vertex component
	localparam int DW   = NBW + 2;     // dot product, signed
	localparam int NNW  = 2 * NW;      // normal component squared
	localparam int N2W  = NNW + 2;     // |n|^2
	localparam int DDW  = 2 * DW;      // dot squared
	localparam int RW   = N2W + B2W;   // |n|^2 * |b|^2
	localparam int CMPW = RW + 18;     // room for 255^2 times either side
	localparam int SHW  = 8;           // shade width

	typedef struct packed {
		logic signed [CW-1:0] a_x;
		logic signed [CW-1:0] a_y;
		logic signed [CW-1:0] a_z;
		logic signed [CW-1:0] b_x;
		logic signed [CW-1:0] b_y;
		logic signed [CW-1:0] b_z;
		logic signed [CW-1:0] c_x;
		logic signed [CW-1:0] c_y;
		logic signed [CW-1:0] c_z;
	} tri_in_t;

	typedef struct packed {
		logic           visible;
		logic [SHW-1:0] shade;
	} tri_out_t;

	// state carried through the shade search
	typedef struct packed {
		logic            ok;
		logic [SHW-1:0]  s;
		logic [CMPW-1:0] s1;   // s * rhs
		logic [CMPW-1:0] s2;   // s^2 * rhs
		logic [CMPW-1:0] lhs;  // (255 * d)^2
		logic [CMPW-1:0] rhs;  // |n|^2 * |b|^2
	} srch_t;

endpackage
`default_nettype wire

// ===== rtl/tbcs_mul.sv =====
`default_nettype none
module tbcs_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [AW-1:0]    a,
	input  wire logic [BW-1:0]    b,
	output logic      [AW+BW-1:0] p
);
	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;

	logic [AL+BL-1:0] pp_ll_s1;
	logic [AL+BH-1:0] pp_lh_s1;
	logic [AH+BL-1:0] pp_hl_s1;
	logic [AH+BH-1:0] pp_hh_s1;

	// partial products, then one registered sum
	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= a[AL-1:0]  * b[BL-1:0];
			pp_lh_s1 <= a[AL-1:0]  * b[BW-1:BL];
			pp_hl_s1 <= a[AW-1:AL] * b[BL-1:0];
			pp_hh_s1 <= a[AW-1:AL] * b[BW-1:BL];
			p <= (AW+BW)'(pp_ll_s1)
			   + ((AW+BW)'(pp_lh_s1) << BL)
			   + ((AW+BW)'(pp_hl_s1) << AL)
			   + ((AW+BW)'(pp_hh_s1) << (AL + BL));
		end
	end
endmodule
`default_nettype wire

// ===== rtl/tbcs_srch.sv =====
`default_nettype none
module tbcs_srch #(
	parameter int BITPOS = 7
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  tbcs_pkg::srch_t    d_in,
	output tbcs_pkg::srch_t    d_out
);
	logic [tbcs_pkg::CMPW-1:0] prod;
	logic                      take;
	tbcs_pkg::srch_t           nxt;

	// (s + 2^k)^2 * r = s^2 r + 2^(k+1) s r + 2^(2k) r
	always_comb begin
		prod = d_in.s2 + (d_in.s1 << (BITPOS + 1)) + (d_in.rhs << (2 * BITPOS));
		take = (prod <= d_in.lhs);
		nxt  = d_in;
		if (take) begin
			nxt.s  = d_in.s | tbcs_pkg::SHW'(1 << BITPOS);
			nxt.s2 = prod;
			nxt.s1 = d_in.s1 + (d_in.rhs << BITPOS);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/triangle_backface_cull_shade_core.sv =====
// throughput: one item per cycle, the whole pipeline stalls as one on out_ready
// stages: edges, products, normal, dot/squares, sums, two split multiplies,
//   scale, then eight shade search steps (one shade bit each)
// reset: arst_n clears all valid bits; data registers are not reset
`default_nettype none
module triangle_backface_cull_shade_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  tbcs_pkg::tri_in_t       in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output tbcs_pkg::tri_out_t      out_data
);
	localparam int NST = 16;

	logic           en;
	logic [NST-1:0] v_q;

	logic signed [tbcs_pkg::EW-1:0]  e1_s1 [3];
	logic signed [tbcs_pkg::EW-1:0]  e2_s1 [3];
	logic signed [tbcs_pkg::CW-1:0]  b_s1  [3];
	logic signed [tbcs_pkg::PW-1:0]  pa_s2 [3];
	logic signed [tbcs_pkg::PW-1:0]  pb_s2 [3];
	logic signed [tbcs_pkg::BBW-1:0] bb_s2 [3];
	logic signed [tbcs_pkg::CW-1:0]  b_s2  [3];
	logic signed [tbcs_pkg::NW-1:0]  n_s3  [3];
	logic signed [tbcs_pkg::CW-1:0]  b_s3  [3];
	logic [tbcs_pkg::B2W-1:0]        b2_s3;
	logic signed [tbcs_pkg::NBW-1:0] nb_s4 [3];
	logic signed [tbcs_pkg::NNW-1:0] nn_s4 [3];
	logic [tbcs_pkg::B2W-1:0]        b2_s4;
	logic [tbcs_pkg::DW-1:0]         dm_s5;
	logic [tbcs_pkg::N2W-1:0]        n2_s5;
	logic [tbcs_pkg::B2W-1:0]        b2_s5;
	logic                            ok_s5, ok_s6, ok_s7;
	logic signed [tbcs_pkg::DW-1:0]  d_sum;
	logic [tbcs_pkg::N2W-1:0]        n2_sum;
	logic [tbcs_pkg::DDW-1:0]        dd_s7;
	logic [tbcs_pkg::RW-1:0]         r_s7;
	logic [tbcs_pkg::CMPW-1:0]       dd_ext;
	tbcs_pkg::srch_t                 sr_s8;
	tbcs_pkg::srch_t                 sr [9];

	assign en       = !v_q[NST-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NST-2:0], in_valid};
		end
	end

	always_comb begin
		d_sum = tbcs_pkg::DW'(nb_s4[0]) + tbcs_pkg::DW'(nb_s4[1])
		      + tbcs_pkg::DW'(nb_s4[2]);
		n2_sum = tbcs_pkg::N2W'(unsigned'(nn_s4[0])) + tbcs_pkg::N2W'(unsigned'(nn_s4[1]))
		       + tbcs_pkg::N2W'(unsigned'(nn_s4[2]));
		dd_ext = tbcs_pkg::CMPW'(dd_s7);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1[0] <= tbcs_pkg::EW'(in_data.a_x) - tbcs_pkg::EW'(in_data.b_x);
			e1_s1[1] <= tbcs_pkg::EW'(in_data.a_y) - tbcs_pkg::EW'(in_data.b_y);
			e1_s1[2] <= tbcs_pkg::EW'(in_data.a_z) - tbcs_pkg::EW'(in_data.b_z);
			e2_s1[0] <= tbcs_pkg::EW'(in_data.c_x) - tbcs_pkg::EW'(in_data.b_x);
			e2_s1[1] <= tbcs_pkg::EW'(in_data.c_y) - tbcs_pkg::EW'(in_data.b_y);
			e2_s1[2] <= tbcs_pkg::EW'(in_data.c_z) - tbcs_pkg::EW'(in_data.b_z);
			b_s1[0]  <= in_data.b_x;
			b_s1[1]  <= in_data.b_y;
			b_s1[2]  <= in_data.b_z;

			pa_s2[0] <= e1_s1[1] * e2_s1[2];
			pb_s2[0] <= e1_s1[2] * e2_s1[1];
			pa_s2[1] <= e1_s1[2] * e2_s1[0];
			pb_s2[1] <= e1_s1[0] * e2_s1[2];
			pa_s2[2] <= e1_s1[0] * e2_s1[1];
			pb_s2[2] <= e1_s1[1] * e2_s1[0];
			for (int i = 0; i < 3; i++) begin
				bb_s2[i] <= b_s1[i] * b_s1[i];
				b_s2[i]  <= b_s1[i];
				n_s3[i]  <= tbcs_pkg::NW'(pa_s2[i]) - tbcs_pkg::NW'(pb_s2[i]);
				b_s3[i]  <= b_s2[i];
				nb_s4[i] <= n_s3[i] * b_s3[i];
				nn_s4[i] <= n_s3[i] * n_s3[i];
			end
			b2_s3 <= tbcs_pkg::B2W'(unsigned'(bb_s2[0])) + tbcs_pkg::B2W'(unsigned'(bb_s2[1]))
			       + tbcs_pkg::B2W'(unsigned'(bb_s2[2]));
			b2_s4 <= b2_s3;

			// zero normal, vertex at camera or facing away: culled
			ok_s5 <= (n2_sum != '0) && (b2_s4 != '0) && !d_sum[tbcs_pkg::DW-1];
			dm_s5 <= d_sum[tbcs_pkg::DW-1] ? '0 : unsigned'(d_sum);
			n2_s5 <= n2_sum;
			b2_s5 <= b2_s4;
			ok_s6 <= ok_s5;
			ok_s7 <= ok_s6;

			// 65025 = 2^16 - 2^9 + 1
			sr_s8.ok  <= ok_s7;
			sr_s8.s   <= '0;
			sr_s8.s1  <= '0;
			sr_s8.s2  <= '0;
			sr_s8.lhs <= (dd_ext << 16) - (dd_ext << 9) + dd_ext;
			sr_s8.rhs <= tbcs_pkg::CMPW'(r_s7);
		end
	end

	tbcs_mul #(.AW(tbcs_pkg::DW), .BW(tbcs_pkg::DW)) u_mul_dd (
		.clk (clk), .en (en), .a (dm_s5), .b (dm_s5), .p (dd_s7)
	);

	tbcs_mul #(.AW(tbcs_pkg::N2W), .BW(tbcs_pkg::B2W)) u_mul_r (
		.clk (clk), .en (en), .a (n2_s5), .b (b2_s5), .p (r_s7)
	);

	assign sr[0] = sr_s8;

	for (genvar j = 0; j < 8; j++) begin : g_srch
		tbcs_srch #(.BITPOS(7 - j)) u_srch (
			.clk (clk), .en (en), .d_in (sr[j]), .d_out (sr[j+1])
		);
	end

	assign out_valid        = v_q[NST-1];
	assign out_data.visible = sr[8].ok;
	assign out_data.shade   = sr[8].ok ? sr[8].s : '0;
endmodule
`default_nettype wire

// ===== rtl/tbcs_chk.sv =====
`default_nettype none
module tbcs_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input tbcs_pkg::tri_out_t      out_data
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// culled item carries no shade
	a_cull_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.visible |-> out_data.shade == '0)
		else $error("culled item with nonzero shade");

	// pipeline only stalls when a result is waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with free output");

	// a stalled output blocks the input
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during output stall");
endmodule

bind triangle_backface_cull_shade_core tbcs_chk u_tbcs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
